// ===== sv/hse_pkg.sv =====
// Package for the heap sort engine: sizes, data and control types, FSM states.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package hse_pkg;

  // Number of values one set can hold
  localparam int unsigned Depth  = 64;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(Depth + 1);

  typedef logic signed [DataW-1:0]  data_t;
  typedef logic        [CountW-1:0] count_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the incoming value in order
    logic pop;  // shift the chain toward cell 0 by one place
  } ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage : hse_pkg

// ===== sv/hse_in_if.sv =====
// Input channel of the heap sort engine: valid/ready plus value and last flag.
// Depends on hse_pkg.
`timescale 1ns / 1ps

interface hse_in_if;
  import hse_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface : hse_in_if

// ===== sv/hse_out_if.sv =====
// Output channel of the heap sort engine: valid/ready plus sorted value and flags.
// Depends on hse_pkg.
`timescale 1ns / 1ps

interface hse_out_if;
  import hse_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  final_res;
  logic  overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);

endinterface : hse_out_if

// ===== sv/hse_cell.sv =====
// One cell of the sorting chain: holds one value, keeps the chain ascending.
// Depends on hse_pkg. Neighbors exchange value and insert-position flags.
`timescale 1ns / 1ps

module hse_cell (
  input  logic           clk_i,
  input  hse_pkg::ctrl_t ctrl_i,
  input  logic           occ_i,        // this cell holds a value of the set
  input  hse_pkg::data_t new_i,        // value being inserted
  input  hse_pkg::data_t left_val_i,   // neighbor toward cell 0
  input  logic           left_lt_i,    // new value goes at or before the left neighbor
  input  hse_pkg::data_t right_val_i,  // neighbor away from cell 0
  output hse_pkg::data_t val_o,
  output logic           lt_o
);
  import hse_pkg::*;

  data_t val_q, val_d;

  // New value belongs here or earlier: cell is empty or holds a larger value
  assign lt_o  = !occ_i || (new_i < val_q);
  assign val_o = val_q;

  // Pop shifts toward cell 0; insert shifts the tail one place away from it
  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop) begin
      val_d = right_val_i;
    end else if (ctrl_i.ins) begin
      if (left_lt_i) begin
        val_d = left_val_i;
      end else if (lt_o) begin
        val_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule : hse_cell

// ===== sv/heap_sort_engine_core.sv =====
// Sorting engine: collects up to Depth signed values, emits them ascending.
// Input: one transfer per cycle while loading; a value is placed in order on arrival.
// Output: after the last transfer, results leave at one per cycle from cell 0 while
// the output is ready; results are registered once the state register turns to drain.
// Values sit in a chain of Depth compare-and-shift cells.
// Reset clears fill count, drop flag, state and output valid; cell contents are not reset.
`timescale 1ns / 1ps

module heap_sort_engine_core (
  input  logic clk_i,
  input  logic rst_ni,
  hse_in_if.sink    in_i,
  hse_out_if.source out_o
);
  import hse_pkg::*;

  state_e state_q, state_d;
  count_t count_q, count_d;
  logic   dropped_q, dropped_d;

  logic   out_valid_q, out_valid_d;
  data_t  out_val_q, out_val_d;
  logic   out_final_q, out_final_d;
  logic   out_ovf_q, out_ovf_d;

  ctrl_t  ctrl;
  logic   take;
  logic   pop;
  logic   room;

  data_t  vals [Depth];
  logic   lts  [Depth];

  assign room = (count_q < count_t'(Depth));
  assign take = in_i.valid && in_i.ready;
  assign pop  = (state_q == ST_DRAIN) && (!out_valid_q || out_o.ready);

  assign ctrl.ins = take && room;
  assign ctrl.pop = pop;

  // Chain of cells, cell 0 holds the smallest value
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    data_t left_val, right_val;
    logic  left_lt;

    if (g == 0) begin : g_first
      assign left_val = '0;
      assign left_lt  = 1'b0;
    end else begin : g_mid
      assign left_val = vals[g-1];
      assign left_lt  = lts[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_body
      assign right_val = vals[g+1];
    end

    hse_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (count_q > count_t'(g)),
      .new_i       (in_i.value),
      .left_val_i  (left_val),
      .left_lt_i   (left_lt),
      .right_val_i (right_val),
      .val_o       (vals[g]),
      .lt_o        (lts[g])
    );
  end

  // Control: load until the last transfer, then drain the chain
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    in_i.ready  = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (take) begin
          if (room) begin
            count_d = count_q + count_t'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          out_valid_d = 1'b1;
          out_val_d   = vals[0];
          out_final_d = (count_q == count_t'(1));
          out_ovf_d   = dropped_q;
          count_d     = count_q - count_t'(1);
          if (count_q == count_t'(1)) begin
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    out_val_q   <= out_val_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.final_res    = out_final_q;
  assign out_o.overflow     = out_ovf_q;

endmodule : heap_sort_engine_core

// ===== tb/sv/hse_order_check.sv =====
// Result checker for the heap sort engine: watches both channels, keeps an ascending
// copy of the set being loaded and compares every result transfer with it.
// Depends on hse_pkg, hse_in_if and hse_out_if.
`timescale 1ns / 1ps

module hse_order_check (
  input  logic clk_i,
  input  logic rst_ni,
  hse_in_if    in_mon,
  hse_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  import hse_pkg::*;

  typedef struct packed {
    data_t value;
    logic  final_res;
    logic  overflow;
  } sorted_res_t;

  // Values of the open set, kept in ascending order as they arrive
  data_t       held_asc[$];
  bit          set_dropped;
  // Results owed by the block, oldest first
  sorted_res_t due_results[$];
  int          err_cnt;

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    sorted_res_t got;
    sorted_res_t want;
    data_t       v;
    int          j;
    if (rst_ni) begin
      // Results first: none may leave in the same cycle its set closes
      if (out_mon.valid && out_mon.ready) begin
        got.value     = out_mon.sorted_value;
        got.final_res = out_mon.final_res;
        got.overflow  = out_mon.overflow;
        if (due_results.size() == 0) begin
          note_error($sformatf("result %0d final=%b ovf=%b with none pending",
                               got.value, got.final_res, got.overflow));
        end else begin
          want = due_results.pop_front();
          if (got.value !== want.value || got.final_res !== want.final_res ||
              got.overflow !== want.overflow)
            note_error($sformatf("exp %0d final=%b ovf=%b, got %0d final=%b ovf=%b",
                                 want.value, want.final_res, want.overflow,
                                 got.value, got.final_res, got.overflow));
        end
      end

      // Input transfer: store in order if room remains, else remember the drop
      if (in_mon.valid && in_mon.ready) begin
        v = in_mon.value;
        if (held_asc.size() < Depth) begin
          held_asc.push_back(v);
          j = held_asc.size() - 1;
          while (j > 0 && held_asc[j-1] > v) begin
            held_asc[j] = held_asc[j-1];
            j--;
          end
          held_asc[j] = v;
        end else begin
          set_dropped = 1'b1;
        end
        // Closing transfer: the whole set is owed, smallest first
        if (in_mon.last) begin
          for (j = 0; j < held_asc.size(); j++) begin
            want.value     = held_asc[j];
            want.final_res = (j == held_asc.size() - 1);
            want.overflow  = set_dropped;
            due_results.push_back(want);
          end
          held_asc.delete();
          set_dropped = 1'b0;
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= due_results.size();
  end

endmodule : hse_order_check

// ===== tb/sv/tb_top.sv =====
// Top of the heap sort engine testbench: clock, reset, stimulus with random gaps and
// output stalls, watchdog and verdict. Depends on hse_pkg, both channel interfaces,
// heap_sort_engine_core and hse_order_check.
`timescale 1ns / 1ps

module tb_top;
  import hse_pkg::*;

  localparam int unsigned StoredTarget = 380;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned DrainWait    = 2 * Depth + 16;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  int    chk_errors;
  int    chk_pending;
  int    sets_sent;
  int    stored_sent;
  int    overfull_sets;
  bit    calm_set;
  bit    timed_out;
  data_t set_vals[$];

  hse_in_if  in_if ();
  hse_out_if out_if ();

  heap_sort_engine_core dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  hse_order_check u_check (
    .clk_i,
    .rst_ni,
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (chk_errors),
    .pending_o (chk_pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of full-range values, a narrow band for duplicates, and the extremes
  function automatic data_t rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 9) return $signed($urandom_range(0, 8)) - 4;
    r = $urandom_range(0, 3);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7FFF_FFFF;
    if (r == 2) return 32'sh0000_0000;
    return 32'shFFFF_FFFF;
  endfunction

  // One input transfer; valid stays high across back-to-back items
  task automatic send_item(input data_t v, input logic l);
    int gap;
    gap = calm_set ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Send set_vals as one set, last flag on the final entry
  task automatic send_set();
    int k;
    calm_set = ($urandom_range(0, 3) == 0);
    for (k = 0; k < set_vals.size(); k++)
      send_item(set_vals[k], k == set_vals.size() - 1);
    sets_sent++;
    stored_sent += (set_vals.size() < Depth) ? set_vals.size() : Depth;
    if (set_vals.size() > Depth) overfull_sets++;
  endtask

  // Result side back-pressure, with occasional long stall-free runs
  initial begin
    int run_len;
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      out_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    int set_idx;
    int n;
    int k;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.last  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        @(posedge clk_i);
        // Directed: single-entry sets at both extremes, duplicates, bit patterns,
        // and a reversed run
        set_vals = '{32'sh7FFF_FFFF};
        send_set();
        set_vals = '{32'sh8000_0000};
        send_set();
        set_vals = '{32'sh0000_0000, 32'shFFFF_FFFF};
        send_set();
        set_vals = '{32'sd5, -32'sd5, 32'sd5, 32'sd5};
        send_set();
        set_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'shAAAA_AAAA, 32'sh5555_5555,
                     32'shFFFF_FFFF, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF};
        send_set();
        set_vals = '{32'sd6, 32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1};
        send_set();

        // Random sets: mostly small, at least one exactly full, a few past capacity
        set_idx = 0;
        while (stored_sent < StoredTarget) begin
          if (set_idx == 0) n = Depth;
          else if (set_idx == 2) n = Depth + 3;
          else if ($urandom_range(0, 11) == 0) n = $urandom_range(Depth - 2, Depth + 8);
          else n = $urandom_range(1, 16);
          set_vals.delete();
          for (k = 0; k < n; k++) set_vals.push_back(rand_value());
          send_set();
          set_idx++;
        end
        in_if.valid <= 1'b0;

        @(posedge clk_i);
        while (chk_pending != 0) @(posedge clk_i);
        repeat (DrainWait) @(posedge clk_i);
      end
      begin
        // Watchdog: cycles with no transfer on either channel
        idle = 0;
        while (idle < IdleLimit) begin
          @(posedge clk_i);
          if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
          else idle++;
        end
        timed_out = 1'b1;
      end
    join_any

    $display("Ran %0d sets holding %0d values, %0d of them overfilled (drops flagged).",
             sets_sent, stored_sent, overfull_sets);
    $display("Extremes, duplicates and single-entry sets ran under random stalls both ways.");
    if (!timed_out && chk_errors == 0 && chk_pending == 0)
      $display("PASS heap_sort_engine_core");
    else
      $display("FAIL heap_sort_engine_core");
    $finish;
  end

endmodule : tb_top

// ===== filelist.f =====
sv/hse_pkg.sv
sv/hse_in_if.sv
sv/hse_out_if.sv
sv/hse_cell.sv
sv/heap_sort_engine_core.sv
tb/sv/hse_order_check.sv
tb/sv/tb_top.sv
